@@ hw/rtl/rrq_pkg.sv @@
`timescale 1ns / 1ps
package rrq_pkg;

  localparam int unsigned QueueDepthDef = 8;

  typedef enum logic [2:0] {
    CMD_SUBMIT  = 3'd0,
    CMD_TAKE    = 3'd1,
    CMD_CLR_CUR = 3'd2,
    CMD_CLR_DOC = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    STS_QUEUED      = 4'd0,
    STS_QUEUED_DROP = 4'd1,
    STS_ALREADY     = 4'd2,
    STS_MOVED       = 4'd3,
    STS_REPLACED    = 4'd4,
    STS_CACHED      = 4'd5,
    STS_DEQUEUED    = 4'd6,
    STS_EMPTY       = 4'd7,
    STS_CLEARED     = 4'd8,
    STS_DOC_CLEARED = 4'd9,
    STS_FOUND       = 4'd10,
    STS_NOT_FOUND   = 4'd11
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN_RD,
    S_SCAN_EV,
    S_TOP_RD,
    S_TOP_EV,
    S_SWAP_WR,
    S_NOMATCH,
    S_SHIFT_RD,
    S_SHIFT_EV,
    S_SHIFT_FIN,
    S_TAKE_RD,
    S_TAKE_EV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  doc;
    logic [15:0] page;
    logic [1:0]  turns;
    logic [23:0] zoom;
    logic [3:0]  level;
    logic [14:0] row;
    logic [14:0] col;
    logic [31:0] stamp;
  } req_t;

  function automatic logic same_key(req_t a, req_t b);
    return (a.doc == b.doc) && (a.page == b.page) && (a.level == b.level) &&
           (a.row == b.row) && (a.col == b.col);
  endfunction

  function automatic logic same_par(req_t a, req_t b);
    return (a.turns == b.turns) && (a.zoom == b.zoom);
  endfunction

endpackage

@@ hw/rtl/rrq_if.sv @@
`timescale 1ns / 1ps
interface rrq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  doc_id;
  logic [15:0] page;
  logic [1:0]  quarter_turns;
  logic [23:0] zoom_code;
  logic [3:0]  tile_level;
  logic [14:0] tile_y;
  logic [14:0] tile_x;
  logic        already_cached;
  logic [31:0] now;

  modport source (output valid, cmd, doc_id, page, quarter_turns, zoom_code, tile_level,
                  tile_y, tile_x, already_cached, now, input ready);
  modport sink (input valid, cmd, doc_id, page, quarter_turns, zoom_code, tile_level,
                tile_y, tile_x, already_cached, now, output ready);
endinterface

interface rrq_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  out_doc;
  logic [15:0] out_page;
  logic [1:0]  out_turns;
  logic [23:0] out_zoom;
  logic [3:0]  out_level;
  logic [14:0] out_row;
  logic [14:0] out_col;
  logic [31:0] delay;
  logic        queue_empty;
  logic        current_abort;

  modport source (output valid, status, out_doc, out_page, out_turns, out_zoom, out_level,
                  out_row, out_col, delay, queue_empty, current_abort, input ready);
  modport sink (input valid, status, out_doc, out_page, out_turns, out_zoom, out_level,
                out_row, out_col, delay, queue_empty, current_abort, output ready);
endinterface

@@ hw/rtl/rrq_mem.sv @@
`timescale 1ns / 1ps
module rrq_mem #(
  parameter int unsigned QUEUE_DEPTH = rrq_pkg::QueueDepthDef,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  rrq_pkg::req_t wdata_i,
  input  logic [IW-1:0] raddr_i,
  output rrq_pkg::req_t rdata_o
);

  rrq_pkg::req_t mem_q [QUEUE_DEPTH];
  rrq_pkg::req_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rrq_ctrl.sv @@
`timescale 1ns / 1ps
module rrq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = rrq_pkg::QueueDepthDef,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrq_req_if.sink       req,
  rrq_rsp_if.source     rsp,
  output logic          mem_we_o,
  output logic [IW-1:0] mem_waddr_o,
  output rrq_pkg::req_t mem_wdata_o,
  output logic [IW-1:0] mem_raddr_o,
  input  rrq_pkg::req_t mem_rdata_i
);

  rrq_pkg::state_e  state_q, state_d;
  rrq_pkg::cmd_e    cmd_q, cmd_d;
  rrq_pkg::status_e status_q, status_d;
  rrq_pkg::req_t    req_q, req_d, cur_q, cur_d, sav_q, sav_d, ent_q, ent_d;
  logic             cached_q, cached_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    keep_q, keep_d, count_q, count_d;
  logic             cur_valid_q, cur_valid_d, cur_abort_q, cur_abort_d;
  logic [31:0]      delay_q, delay_d;
  logic             out_valid_q, out_valid_d;
  rrq_pkg::status_e out_status_q, out_status_d;
  rrq_pkg::req_t    out_ent_q, out_ent_d;
  logic [31:0]      out_delay_q, out_delay_d;
  logic             out_empty_q, out_empty_d, out_abort_q, out_abort_d;

  logic          cur_key, cur_par, mem_key, mem_par, last, full, out_free;
  logic [CW-1:0] cnt_m1;
  rrq_pkg::req_t in_req;

  assign in_req = '{doc: req.doc_id, page: req.page, turns: req.quarter_turns,
                    zoom: req.zoom_code, level: req.tile_level, row: req.tile_y,
                    col: req.tile_x, stamp: req.now};

  assign cur_key  = cur_valid_q && rrq_pkg::same_key(cur_q, req_q);
  assign cur_par  = rrq_pkg::same_par(cur_q, req_q);
  assign mem_key  = rrq_pkg::same_key(mem_rdata_i, req_q);
  assign mem_par  = rrq_pkg::same_par(mem_rdata_i, req_q);
  assign cnt_m1   = count_q - CW'(1);
  assign last     = (CW'(idx_q) + CW'(1)) == count_q;
  assign full     = count_q == CW'(QUEUE_DEPTH);
  assign out_free = !out_valid_q || rsp.ready;

  assign req.ready = state_q == rrq_pkg::S_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrq_pkg::S_IDLE:      if (req.valid) state_d = rrq_pkg::S_DISP;
      rrq_pkg::S_DISP: begin
        case (cmd_q)
          rrq_pkg::CMD_SUBMIT: begin
            if (cur_key && cur_par) state_d = rrq_pkg::S_DONE;
            else if (count_q == '0) state_d = rrq_pkg::S_NOMATCH;
            else state_d = rrq_pkg::S_SCAN_RD;
          end
          rrq_pkg::CMD_TAKE:
            state_d = (count_q == '0) ? rrq_pkg::S_DONE : rrq_pkg::S_TAKE_RD;
          rrq_pkg::CMD_CLR_DOC:
            state_d = (count_q == '0) ? rrq_pkg::S_DONE : rrq_pkg::S_SCAN_RD;
          rrq_pkg::CMD_QUERY:
            state_d = (cur_key || count_q == '0) ? rrq_pkg::S_DONE : rrq_pkg::S_SCAN_RD;
          default: state_d = rrq_pkg::S_DONE;
        endcase
      end
      rrq_pkg::S_SCAN_RD:   state_d = rrq_pkg::S_SCAN_EV;
      rrq_pkg::S_SCAN_EV: begin
        case (cmd_q)
          rrq_pkg::CMD_SUBMIT: begin
            if (mem_key) state_d = mem_par ? rrq_pkg::S_TOP_RD : rrq_pkg::S_DONE;
            else if (last) state_d = rrq_pkg::S_NOMATCH;
            else state_d = rrq_pkg::S_SCAN_RD;
          end
          rrq_pkg::CMD_QUERY:
            state_d = (mem_key || last) ? rrq_pkg::S_DONE : rrq_pkg::S_SCAN_RD;
          default: state_d = last ? rrq_pkg::S_DONE : rrq_pkg::S_SCAN_RD;
        endcase
      end
      rrq_pkg::S_TOP_RD:    state_d = rrq_pkg::S_TOP_EV;
      rrq_pkg::S_TOP_EV:    state_d = rrq_pkg::S_SWAP_WR;
      rrq_pkg::S_SWAP_WR:   state_d = rrq_pkg::S_DONE;
      rrq_pkg::S_NOMATCH:
        state_d = (!cached_q && full) ? rrq_pkg::S_SHIFT_RD : rrq_pkg::S_DONE;
      rrq_pkg::S_SHIFT_RD:  state_d = rrq_pkg::S_SHIFT_EV;
      rrq_pkg::S_SHIFT_EV:
        state_d = (idx_q == IW'(QUEUE_DEPTH - 2)) ? rrq_pkg::S_SHIFT_FIN
                                                  : rrq_pkg::S_SHIFT_RD;
      rrq_pkg::S_SHIFT_FIN: state_d = rrq_pkg::S_DONE;
      rrq_pkg::S_TAKE_RD:   state_d = rrq_pkg::S_TAKE_EV;
      rrq_pkg::S_TAKE_EV:   state_d = rrq_pkg::S_DONE;
      rrq_pkg::S_DONE:      if (out_free) state_d = rrq_pkg::S_IDLE;
      default:              state_d = rrq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    cmd_d        = cmd_q;
    req_d        = req_q;
    cached_d     = cached_q;
    status_d     = status_q;
    cur_d        = cur_q;
    sav_d        = sav_q;
    ent_d        = ent_q;
    idx_d        = idx_q;
    keep_d       = keep_q;
    count_d      = count_q;
    cur_valid_d  = cur_valid_q;
    cur_abort_d  = cur_abort_q;
    delay_d      = delay_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_delay_d  = out_delay_q;
    out_empty_d  = out_empty_q;
    out_abort_d  = out_abort_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q;
    mem_wdata_o  = mem_rdata_i;
    mem_raddr_o  = idx_q;

    case (state_q)
      rrq_pkg::S_IDLE: begin
        if (req.valid) begin
          cmd_d    = rrq_pkg::cmd_e'(req.cmd);
          req_d    = in_req;
          cached_d = req.already_cached;
        end
      end
      rrq_pkg::S_DISP: begin
        idx_d    = '0;
        keep_d   = '0;
        ent_d    = '0;
        delay_d  = '0;
        status_d = rrq_pkg::STS_NOT_FOUND;
        case (cmd_q)
          rrq_pkg::CMD_SUBMIT: begin
            if (cur_key) begin
              if (cur_par) status_d = rrq_pkg::STS_ALREADY;
              else cur_abort_d = 1'b1;
            end
          end
          rrq_pkg::CMD_TAKE:
            if (count_q == '0) status_d = rrq_pkg::STS_EMPTY;
          rrq_pkg::CMD_CLR_CUR: begin
            cur_valid_d = 1'b0;
            cur_abort_d = 1'b0;
            status_d    = rrq_pkg::STS_CLEARED;
          end
          rrq_pkg::CMD_CLR_DOC: begin
            if (cur_valid_q && cur_q.doc == req_q.doc) cur_abort_d = 1'b1;
            status_d = rrq_pkg::STS_DOC_CLEARED;
          end
          rrq_pkg::CMD_QUERY: begin
            if (cur_key) begin
              delay_d  = req_q.stamp - cur_q.stamp;
              status_d = rrq_pkg::STS_FOUND;
            end
          end
          default: ;
        endcase
      end
      rrq_pkg::S_SCAN_EV: begin
        idx_d = idx_q + IW'(1);
        case (cmd_q)
          rrq_pkg::CMD_SUBMIT: begin
            if (mem_key) begin
              idx_d = idx_q;
              sav_d = mem_rdata_i;
              if (!mem_par) begin
                mem_we_o          = 1'b1;
                mem_wdata_o.turns = req_q.turns;
                mem_wdata_o.zoom  = req_q.zoom;
                status_d          = rrq_pkg::STS_REPLACED;
              end
            end
          end
          rrq_pkg::CMD_QUERY: begin
            if (mem_key) begin
              delay_d  = req_q.stamp - mem_rdata_i.stamp;
              status_d = rrq_pkg::STS_FOUND;
            end
          end
          default: begin
            // compaction: survivors slide down to the keep pointer
            if (mem_rdata_i.doc != req_q.doc) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = keep_q[IW-1:0];
              keep_d      = keep_q + CW'(1);
            end
            if (last) count_d = keep_d;
          end
        endcase
      end
      rrq_pkg::S_TOP_RD:  mem_raddr_o = cnt_m1[IW-1:0];
      rrq_pkg::S_TOP_EV:  mem_we_o = 1'b1;
      rrq_pkg::S_SWAP_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_m1[IW-1:0];
        mem_wdata_o = sav_q;
        status_d    = rrq_pkg::STS_MOVED;
      end
      rrq_pkg::S_NOMATCH: begin
        idx_d = '0;
        if (cached_q) begin
          status_d = rrq_pkg::STS_CACHED;
        end else if (!full) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = count_q[IW-1:0];
          mem_wdata_o = req_q;
          count_d     = count_q + CW'(1);
          status_d    = rrq_pkg::STS_QUEUED;
        end
      end
      rrq_pkg::S_SHIFT_RD: mem_raddr_o = idx_q + IW'(1);
      rrq_pkg::S_SHIFT_EV: begin
        mem_we_o = 1'b1;
        idx_d    = idx_q + IW'(1);
      end
      rrq_pkg::S_SHIFT_FIN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = IW'(QUEUE_DEPTH - 1);
        mem_wdata_o = req_q;
        status_d    = rrq_pkg::STS_QUEUED_DROP;
      end
      rrq_pkg::S_TAKE_RD: mem_raddr_o = cnt_m1[IW-1:0];
      rrq_pkg::S_TAKE_EV: begin
        ent_d       = mem_rdata_i;
        cur_d       = mem_rdata_i;
        cur_valid_d = 1'b1;
        cur_abort_d = 1'b0;
        count_d     = cnt_m1;
        status_d    = rrq_pkg::STS_DEQUEUED;
      end
      rrq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_ent_d    = ent_q;
          out_delay_d  = delay_q;
          out_empty_d  = count_q == '0;
          out_abort_d  = cur_valid_q && cur_abort_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrq_pkg::S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_abort_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      cur_abort_q <= cur_abort_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    req_q        <= req_d;
    cached_q     <= cached_d;
    status_q     <= status_d;
    sav_q        <= sav_d;
    ent_q        <= ent_d;
    idx_q        <= idx_d;
    keep_q       <= keep_d;
    delay_q      <= delay_d;
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_delay_q  <= out_delay_d;
    out_empty_q  <= out_empty_d;
    out_abort_q  <= out_abort_d;
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.out_doc       = out_ent_q.doc;
  assign rsp.out_page      = out_ent_q.page;
  assign rsp.out_turns     = out_ent_q.turns;
  assign rsp.out_zoom      = out_ent_q.zoom;
  assign rsp.out_level     = out_ent_q.level;
  assign rsp.out_row       = out_ent_q.row;
  assign rsp.out_col       = out_ent_q.col;
  assign rsp.delay         = out_delay_q;
  assign rsp.queue_empty   = out_empty_q;
  assign rsp.current_abort = out_abort_q;

endmodule

@@ hw/rtl/render_request_queue_top.sv @@
`timescale 1ns / 1ps
// Deduplicating render-request stack.
// req_i carries one command word (submit, take, clear current, clear document,
// query); rsp_o returns exactly one result word for each, in order.
// Both channels move a word on a clock edge where valid and ready are high.
// Queued requests live in a single-port-write, registered-read memory of
// QUEUE_DEPTH entries; the current request and the fill count sit in flops.
// The work after acceptance depends on the command: clear current, take or
// query on an empty queue and a hit on the current request answer without a
// memory access; take reads the top entry; query, clear document and submit
// scan the queued entries; a submit with no queued hit then queues the request
// or reports it cached; a swap to top rewrites the top entry, and a push into a
// full queue shifts every entry down to drop the oldest.
// One command is worked at a time; the entry scan reads and then compares
// one entry at a time through the memory read port.
// The result sits in an output register; the next command is accepted once
// it is loaded, so a stalled rsp_o holds only the following result back.
// Reset (rst_ni low, asynchronous) empties the queue and drops the current
// request; memory contents are left as they are.
module render_request_queue_top #(
  parameter int unsigned QUEUE_DEPTH = rrq_pkg::QueueDepthDef,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrq_req_if.sink    req_i,
  rrq_rsp_if.source  rsp_o
);

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  rrq_pkg::req_t mem_wdata, mem_rdata;

  rrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // request store
  rrq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
